FILE: hdl/rgbatt_pkg.sv
// Shared types and constants for the RGBA raster-to-tile converter.
// Used by rgbatt_ctrl, rgbatt_datapath and rgba_to_tiled_texture_top.
`default_nettype none

package rgbatt_pkg;

  // Tile index width: the column counter is 8 bits, so at most 64 tiles per band.
  localparam int TILE_W = 6;

  localparam logic [12:0] ROW_LIMIT = 13'd4096;

  // APB register select (byte address bit 2)
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef struct packed {
    logic              accept;   // pixel transfer on the input channel
    logic              rd_en;    // read one tile row from the column banks
    logic [1:0]        row;      // tile row being read
    logic [TILE_W-1:0] tile;     // tile being read
    logic              push;     // move the assembled tile to the output register
  } cmd_t;

  typedef struct packed {
    logic emit_now;   // the current pixel closes a band
    logic out_free;   // output register can take a tile this cycle
    logic last_tile;  // tile in cmd is the last of the band
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/rgbatt_ctrl.sv
// Controller for the tile converter: pixel intake and band drain sequencing.
// Depends on rgbatt_pkg for the command and status structs.
`default_nettype none

module rgbatt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_valid,
  output logic                    s_ready,
  input  wire rgbatt_pkg::status_t sts,
  output rgbatt_pkg::cmd_t        cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SETTLE, ST_PUSH} state_t;

  state_t                        state;
  logic [rgbatt_pkg::TILE_W-1:0] tile;
  logic [1:0]                    row;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tile  <= '0;
      row   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_valid && sts.emit_now) begin
            state <= ST_READ;
            tile  <= '0;
            row   <= '0;
          end
        end
        ST_READ: begin
          if (row == 2'd3) begin
            state <= ST_SETTLE;
          end else begin
            row <= row + 2'd1;
          end
        end
        ST_SETTLE: begin
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (sts.out_free) begin
            if (sts.last_tile) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_READ;
              tile  <= tile + rgbatt_pkg::TILE_W'(1);
              row   <= '0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_ready    = (state == ST_IDLE);
  assign cmd.accept = s_valid && (state == ST_IDLE);
  assign cmd.rd_en  = (state == ST_READ);
  assign cmd.row    = row;
  assign cmd.tile   = tile;
  assign cmd.push   = (state == ST_PUSH) && sts.out_free;

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> sts.out_free)
    else $error("tile pushed into a full output register");

  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.emit_now) |=> (cmd.rd_en && cmd.row == 2'd0 && cmd.tile == '0))
    else $error("band drain did not start at tile 0 row 0");

  a_read_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && cmd.row != 2'd3) |=> (cmd.rd_en && cmd.row == $past(cmd.row) + 2'd1))
    else $error("tile rows not read in order");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && cmd.row == 2'd3) |=> (!cmd.rd_en && !cmd.push && !cmd.accept))
    else $error("activity during tile settle cycle");

endmodule

`default_nettype wire

FILE: hdl/rgbatt_datapath.sv
// Datapath for the tile converter: counters, four column banks of the band
// store, tile assembly and the output register. Depends on rgbatt_pkg.
`default_nettype none

module rgbatt_datapath #(
  parameter int STORE_COLS = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [8:0]          w_eff,
  input  wire logic [12:0]         h_eff,
  input  wire logic [31:0]         s_data,
  input  wire rgbatt_pkg::cmd_t    cmd,
  output rgbatt_pkg::status_t      sts,
  output logic [511:0]             m_data,
  output logic                     m_valid,
  input  wire logic                m_ready,
  output logic                     m_last,
  output logic                     m_user
);

  localparam int COLS4      = (STORE_COLS + 3) / 4;
  localparam int TW         = (COLS4 > 1) ? $clog2(COLS4) : 1;
  localparam int AW         = TW + 2;
  localparam int BANK_DEPTH = 4 * (1 << TW);
  localparam logic [8:0] MAXW9 = 9'(STORE_COLS);

  logic [7:0]  column_count;
  logic [11:0] row_count;
  logic        row_end;
  logic        img_end;
  logic [7:0]  col_clamp;
  logic [31:0] pix;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  logic [1:0]  drain_row;
  logic        drain_img_end;

  logic [31:0] rdata [4];
  logic        rd_en_q;
  logic [1:0]  rd_row_q;
  logic [rgbatt_pkg::TILE_W-1:0] rd_tile_q;

  logic [3:0]  keep;
  logic [63:0] ar_cat;
  logic [63:0] gb_cat;
  logic [63:0] ar_row [4];
  logic [63:0] gb_row [4];
  logic [6:0]  tiles;

  // Pixel word {alpha, red, green, blue}: AR halfword on top, GB below
  assign pix = {s_data[31:24], s_data[7:0], s_data[15:8], s_data[23:16]};

  assign row_end   = ({1'b0, column_count} + 9'd1) >= w_eff;
  assign img_end   = ({1'b0, row_count} + 13'd1) >= h_eff;
  assign col_clamp = ({1'b0, column_count} >= MAXW9) ? 8'(STORE_COLS - 1) : column_count;
  assign waddr     = {row_count[1:0], col_clamp[TW+1:2]};
  assign raddr     = {cmd.row, cmd.tile[TW-1:0]};

  assign tiles         = 7'((w_eff + 9'd3) >> 2);
  assign sts.emit_now  = row_end && (row_count[1:0] == 2'd3 || img_end);
  assign sts.out_free  = !m_valid || m_ready;
  assign sts.last_tile = ({1'b0, cmd.tile} + 7'd1) == tiles;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.accept) begin
      if (!row_end) begin
        column_count <= column_count + 8'd1;
      end else begin
        column_count <= '0;
        row_count    <= img_end ? 12'd0 : row_count + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && sts.emit_now) begin
      drain_row     <= row_count[1:0];
      drain_img_end <= img_end;
    end
  end

  // Column bank c holds columns with x mod 4 == c
  for (genvar c = 0; c < 4; c++) begin : g_bank
    logic [31:0] mem [BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (cmd.accept && col_clamp[1:0] == 2'(c)) begin
        mem[waddr] <= pix;
      end
      if (cmd.rd_en) begin
        rdata[c] <= mem[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_en_q <= 1'b0;
    end else begin
      rd_en_q <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_row_q  <= cmd.row;
    rd_tile_q <= cmd.tile;
  end

  // Mask positions past the width or below the last row of the band
  always_comb begin
    logic [7:0] x;
    x = '0;
    for (int c = 0; c < 4; c++) begin
      x       = {rd_tile_q, 2'(c)};
      keep[c] = ({1'b0, x} < w_eff) && (rd_row_q <= drain_row);
    end
    ar_cat = {keep[0] ? rdata[0][31:16] : 16'd0, keep[1] ? rdata[1][31:16] : 16'd0,
              keep[2] ? rdata[2][31:16] : 16'd0, keep[3] ? rdata[3][31:16] : 16'd0};
    gb_cat = {keep[0] ? rdata[0][15:0] : 16'd0, keep[1] ? rdata[1][15:0] : 16'd0,
              keep[2] ? rdata[2][15:0] : 16'd0, keep[3] ? rdata[3][15:0] : 16'd0};
  end

  always_ff @(posedge clk) begin
    if (rd_en_q) begin
      ar_row[rd_row_q] <= ar_cat;
      gb_row[rd_row_q] <= gb_cat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.push) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      m_data <= {gb_row[3], gb_row[2], gb_row[1], gb_row[0],
                 ar_row[3], ar_row[2], ar_row[1], ar_row[0]};
      m_last <= sts.last_tile;
      m_user <= sts.last_tile && drain_img_end;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rgba_to_tiled_texture_top.sv
// RGBA8 raster-to-4x4-tile converter (AR/GB split), top level with APB registers.
// Depends on rgbatt_pkg, rgbatt_ctrl and rgbatt_datapath.
//
// Usage:
//   s_axis carries one RGBA pixel per transfer in raster order. Every pixel
//   is written to a four-row band store. The pixel that ends every fourth row,
//   or the last row of the image, starts a band drain: ceil(width/4) tiles go
//   out on m_axis, one per transfer, left to right. tlast marks the last tile
//   of a band, tuser the last tile of the image.
//   Each tile of a drain is built by four row reads of the column banks,
//   a settle step and a push into the output register, in that order;
//   outside a drain one pixel is taken every cycle.
//   s_axis_tready is low for the whole drain.
//   If the receiver stalls, the tile waits in the output register and the
//   drain holds in its push step until the transfer completes.
//   Reset clears the counters, the output valid and sets both registers to
//   256; the band store is not cleared (every unmasked read entry is written first).
//   Write the width and height registers only between images or while idle.
`default_nettype none

module rgba_to_tiled_texture_top #(
  parameter int STORE_COLS = 256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // APB configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // pixel input
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  // tile output
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [511:0]      m_axis_tdata,   // tile_word_0[63:0] .. tile_word_7[511:448]
  output logic              m_axis_tlast,   // band_done
  output logic              m_axis_tuser    // image_done
);

  localparam logic [8:0] MAXW9 = 9'(STORE_COLS);

  logic [8:0]  frame_cols;
  logic [12:0] frame_rows;
  logic [8:0]  w_eff;
  logic [12:0] h_eff;
  logic        reg_wr;

  rgbatt_pkg::cmd_t    cmd;
  rgbatt_pkg::status_t sts;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  // Register select is byte address bit 2; the low two bits are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cols <= 9'd256;
      frame_rows <= 13'd256;
    end else if (reg_wr) begin
      case (paddr[2])
        rgbatt_pkg::REG_COLS: frame_cols <= pwdata[8:0];
        rgbatt_pkg::REG_ROWS: frame_rows <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rgbatt_pkg::REG_COLS: prdata = {23'd0, frame_cols};
      rgbatt_pkg::REG_ROWS: prdata = {19'd0, frame_rows};
      default:              prdata = '0;
    endcase
  end

  // Clamp out-of-range sizes: zero counts as one, large values saturate
  assign w_eff = (frame_cols == 9'd0) ? 9'd1 :
                 (frame_cols > MAXW9) ? MAXW9 : frame_cols;
  assign h_eff = (frame_rows == 13'd0) ? 13'd1 :
                 (frame_rows > rgbatt_pkg::ROW_LIMIT) ? rgbatt_pkg::ROW_LIMIT :
                 frame_rows;

  rgbatt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  rgbatt_datapath #(
    .STORE_COLS (STORE_COLS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .s_data  (s_axis_tdata),
    .cmd     (cmd),
    .sts     (sts),
    .m_data  (m_axis_tdata),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_last  (m_axis_tlast),
    .m_user  (m_axis_tuser)
  );

endmodule

`default_nettype wire
